// ===== hw/rtl/ghcc_pkg.sv =====
package ghcc_pkg;

    // Field widths
    localparam int TIME_W     = 32;
    localparam int SAMPLE_W   = 10;
    localparam int TEMP_W     = 8;
    localparam int HUM_W      = 7;
    localparam int HALF_W     = 31;
    localparam int SENSOR_MAX = 4;

    // Stream and configuration port widths
    localparam int S_DATA_W  = 128;
    localparam int M_DATA_W  = 8;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 32;

    // Default sensor counts
    localparam int LIGHT_SENSORS_DEF = 1;
    localparam int SOIL_SENSORS_DEF  = 1;

    // Fixed pump lockout after a timeout stop
    localparam logic [TIME_W-1:0] LOCKOUT_MS = 32'd5000;

    // Register reset values
    localparam logic [SAMPLE_W-1:0] LIGHT_TH_RST     = 10'd405;
    localparam logic [SAMPLE_W-1:0] SOIL_TH_RST      = 10'd500;
    localparam logic [TEMP_W-1:0]   HEAT_TH_RST      = 8'sd20;
    localparam logic [HUM_W-1:0]    HUM_HIGH_RST     = 7'd75;
    localparam logic [TIME_W-1:0]   PUMP_MAX_RST     = 32'd5000;
    localparam logic [TIME_W-1:0]   VENT_INTERVAL_RST = 32'd3600000;
    localparam logic [TIME_W-1:0]   VENT_DURATION_RST = 32'd60000;
    localparam logic [HALF_W-1:0]   HALF_CYCLE_RST   = 31'd10000;

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LIGHT_TH      = 3'd0,
        CFG_SOIL_TH       = 3'd1,
        CFG_HEAT_TH       = 3'd2,
        CFG_HUM_HIGH      = 3'd3,
        CFG_PUMP_MAX      = 3'd4,
        CFG_VENT_INTERVAL = 3'd5,
        CFG_VENT_DURATION = 3'd6,
        CFG_HALF_CYCLE    = 3'd7
    } cfg_reg_t;

    // Register file contents handed to the datapath
    typedef struct packed {
        logic [SAMPLE_W-1:0]      light_threshold;
        logic [SAMPLE_W-1:0]      soil_threshold;
        logic signed [TEMP_W-1:0] heat_threshold;
        logic [HUM_W-1:0]         humidity_high;
        logic [TIME_W-1:0]        pump_max_ms;
        logic [TIME_W-1:0]        vent_interval_ms;
        logic [TIME_W-1:0]        vent_duration_ms;
        logic [HALF_W-1:0]        half_cycle_ms;
    } cfg_t;

endpackage

// ===== hw/rtl/ghcc_cfg_regs.sv =====
module ghcc_cfg_regs
    import ghcc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr_valid,
    input  logic [CFG_IDX_W-1:0] wr_index,
    input  logic [CFG_DAT_W-1:0] wr_data,
    output cfg_t                 cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Decode the write index and update one register
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_valid)
        begin
            unique case (cfg_reg_t'(wr_index))
                CFG_LIGHT_TH:      cfg_next.light_threshold  = wr_data[SAMPLE_W-1:0];
                CFG_SOIL_TH:       cfg_next.soil_threshold   = wr_data[SAMPLE_W-1:0];
                CFG_HEAT_TH:       cfg_next.heat_threshold   = wr_data[TEMP_W-1:0];
                CFG_HUM_HIGH:      cfg_next.humidity_high    = wr_data[HUM_W-1:0];
                CFG_PUMP_MAX:      cfg_next.pump_max_ms      = wr_data[TIME_W-1:0];
                CFG_VENT_INTERVAL: cfg_next.vent_interval_ms = wr_data[TIME_W-1:0];
                CFG_VENT_DURATION: cfg_next.vent_duration_ms = wr_data[TIME_W-1:0];
                CFG_HALF_CYCLE:    cfg_next.half_cycle_ms    = wr_data[HALF_W-1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.light_threshold  <= LIGHT_TH_RST;
            cfg_reg.soil_threshold   <= SOIL_TH_RST;
            cfg_reg.heat_threshold   <= HEAT_TH_RST;
            cfg_reg.humidity_high    <= HUM_HIGH_RST;
            cfg_reg.pump_max_ms      <= PUMP_MAX_RST;
            cfg_reg.vent_interval_ms <= VENT_INTERVAL_RST;
            cfg_reg.vent_duration_ms <= VENT_DURATION_RST;
            cfg_reg.half_cycle_ms    <= HALF_CYCLE_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== hw/rtl/greenhouse_climate_controller_unit.sv =====
// Greenhouse climate controller. Each control tick word (timestamp, light and soil
// samples, temperature, humidity) yields one result word with lamp, heater, pump and
// vent drive bits and the night flag. A tick passes an input register and an output
// register, from which the result word is presented; a new tick is taken every cycle,
// with the only limit being back-pressure on the result side. All timing is modulo 2^32
// on the tick timestamp; the pump lockout after a timeout is 5000 ms.
// Only the first LIGHT_SENSORS / SOIL_SENSORS samples (1 to 4) enter the means.
// Registers may be written only while no tick is in flight.
module greenhouse_climate_controller_unit
    import ghcc_pkg::*;
#(
    parameter int LIGHT_SENSORS = LIGHT_SENSORS_DEF,
    parameter int SOIL_SENSORS  = SOIL_SENSORS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    // Tick input
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // now_ms, light_sample_0..3, soil_sample_0..3, temperature, humidity, zero pad
    input  logic [S_DATA_W-1:0]  s_axis_tdata,
    // humidity_valid
    input  logic [0:0]           s_axis_tuser,
    // Result output
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // lamp_on, heater_on, pump_on, vent_on, night, zero pad
    output logic [M_DATA_W-1:0]  m_axis_tdata,
    // Register writes
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data
);

    localparam int LIGHT_N = (LIGHT_SENSORS < 1) ? 1 :
                             (LIGHT_SENSORS > SENSOR_MAX) ? SENSOR_MAX : LIGHT_SENSORS;
    localparam int SOIL_N  = (SOIL_SENSORS < 1) ? 1 :
                             (SOIL_SENSORS > SENSOR_MAX) ? SENSOR_MAX : SOIL_SENSORS;
    localparam int LIGHT_SUM_W = SAMPLE_W + $clog2(LIGHT_N) + 1;
    localparam int SOIL_SUM_W  = SAMPLE_W + $clog2(SOIL_N) + 1;

    localparam int LIGHT_LO = TIME_W;
    localparam int SOIL_LO  = LIGHT_LO + SENSOR_MAX * SAMPLE_W;
    localparam int TEMP_LO  = SOIL_LO + SENSOR_MAX * SAMPLE_W;
    localparam int HUM_LO   = TEMP_LO + TEMP_W;

    cfg_t cfg;

    // Configuration registers
    ghcc_cfg_regs u_cfg_regs
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    assign cfg_ready = 1'b1;

    // Flow control
    logic in_valid_reg;
    logic out_valid_reg;
    logic out_take;
    logic in_take;
    logic advance;

    assign out_take      = !out_valid_reg || m_axis_tready;
    assign advance       = in_valid_reg && out_take;
    assign s_axis_tready = !in_valid_reg || out_take;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    // Input register
    logic [TIME_W-1:0]        now_reg;
    logic [SAMPLE_W-1:0]      light_reg [SENSOR_MAX];
    logic [SAMPLE_W-1:0]      soil_reg  [SENSOR_MAX];
    logic signed [TEMP_W-1:0] temp_reg;
    logic [HUM_W-1:0]         hum_reg;
    logic                     hum_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            now_reg       <= s_axis_tdata[TIME_W-1:0];
            for (int k = 0; k < SENSOR_MAX; k++)
            begin
                light_reg[k] <= s_axis_tdata[LIGHT_LO + k*SAMPLE_W +: SAMPLE_W];
                soil_reg[k]  <= s_axis_tdata[SOIL_LO + k*SAMPLE_W +: SAMPLE_W];
            end
            temp_reg      <= s_axis_tdata[TEMP_LO +: TEMP_W];
            hum_reg       <= s_axis_tdata[HUM_LO +: HUM_W];
            hum_valid_reg <= s_axis_tuser[0];
        end
    end

    // Controller state
    logic [TIME_W-1:0] cycle_start_reg,   cycle_start_next;
    logic              pump_running_reg,  pump_running_next;
    logic [TIME_W-1:0] pump_start_reg,    pump_start_next;
    logic [TIME_W-1:0] lockout_start_reg, lockout_start_next;
    logic              pump_locked_reg,   pump_locked_next;
    logic              vent_active_reg,   vent_active_next;
    logic [TIME_W-1:0] vent_mark_reg,     vent_mark_next;

    // Day/night phase
    logic [TIME_W-1:0] cycle_elapsed;
    logic              in_day;
    logic              in_night;
    logic              night;

    assign cycle_elapsed = now_reg - cycle_start_reg;
    assign in_day        = cycle_elapsed < {1'b0, cfg.half_cycle_ms};
    assign in_night      = cycle_elapsed < {cfg.half_cycle_ms, 1'b0};
    assign night         = !in_day && in_night;
    assign cycle_start_next = (in_day || in_night) ? cycle_start_reg : now_reg;

    // Mean above threshold: floor(sum / n) > th is sum > n * th + n - 1
    logic [LIGHT_SUM_W-1:0] light_sum;
    logic [LIGHT_SUM_W-1:0] light_limit;
    logic [SOIL_SUM_W-1:0]  soil_sum;
    logic [SOIL_SUM_W-1:0]  soil_limit;

    always_comb
    begin
        light_sum = '0;
        for (int k = 0; k < LIGHT_N; k++)
        begin
            light_sum = light_sum + LIGHT_SUM_W'(light_reg[k]);
        end
        soil_sum = '0;
        for (int k = 0; k < SOIL_N; k++)
        begin
            soil_sum = soil_sum + SOIL_SUM_W'(soil_reg[k]);
        end
    end

    assign light_limit = LIGHT_SUM_W'(LIGHT_N) * LIGHT_SUM_W'(cfg.light_threshold)
                       + LIGHT_SUM_W'(LIGHT_N - 1);
    assign soil_limit  = SOIL_SUM_W'(SOIL_N) * SOIL_SUM_W'(cfg.soil_threshold)
                       + SOIL_SUM_W'(SOIL_N - 1);

    logic lamp_on;
    logic heater_on;
    logic water_needed;

    assign lamp_on      = !night && (light_sum > light_limit);
    assign heater_on    = temp_reg < cfg.heat_threshold;
    assign water_needed = soil_sum > soil_limit;

    // Ventilation schedule; a run that starts this tick ends at once only for zero duration
    logic [TIME_W-1:0] vent_elapsed;
    logic              vent_start;
    logic              vent_stop;

    assign vent_elapsed = now_reg - vent_mark_reg;
    assign vent_start   = !vent_active_reg && (vent_elapsed >= cfg.vent_interval_ms);
    assign vent_stop    = vent_start ? (cfg.vent_duration_ms == '0)
                                     : (vent_active_reg &&
                                        (vent_elapsed >= cfg.vent_duration_ms));

    always_comb
    begin
        vent_active_next = vent_active_reg;
        vent_mark_next   = vent_mark_reg;
        if (vent_start)
        begin
            vent_active_next = 1'b1;
            vent_mark_next   = now_reg;
        end
        if (vent_stop)
        begin
            vent_active_next = 1'b0;
            vent_mark_next   = now_reg;
        end
    end

    // Pump run, timeout and lockout
    logic pump_timeout;
    logic lock_expired;
    logic lock_set;

    assign pump_timeout = (now_reg - pump_start_reg) > cfg.pump_max_ms;
    assign lock_expired = (now_reg - lockout_start_reg) > LOCKOUT_MS;

    always_comb
    begin
        pump_running_next  = pump_running_reg;
        pump_start_next    = pump_start_reg;
        lockout_start_next = lockout_start_reg;
        lock_set           = 1'b0;
        if (pump_running_reg)
        begin
            if (!water_needed)
            begin
                pump_running_next = 1'b0;
            end
            else if (pump_timeout)
            begin
                pump_running_next  = 1'b0;
                lockout_start_next = now_reg;
                lock_set           = 1'b1;
            end
        end
        else if (water_needed && !pump_locked_reg)
        begin
            pump_running_next = 1'b1;
            pump_start_next   = now_reg;
        end
        // A lockout set this tick has zero elapsed time and holds
        pump_locked_next = lock_set || (pump_locked_reg && !lock_expired);
    end

    logic vent_on;

    assign vent_on = vent_active_next || (hum_valid_reg && (hum_reg > cfg.humidity_high))
                   || heater_on || pump_running_next;

    // Commit state when the tick moves into the output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cycle_start_reg   <= '0;
            pump_running_reg  <= 1'b0;
            pump_start_reg    <= '0;
            lockout_start_reg <= '0;
            pump_locked_reg   <= 1'b0;
            vent_active_reg   <= 1'b0;
            vent_mark_reg     <= '0;
        end
        else if (advance)
        begin
            cycle_start_reg   <= cycle_start_next;
            pump_running_reg  <= pump_running_next;
            pump_start_reg    <= pump_start_next;
            lockout_start_reg <= lockout_start_next;
            pump_locked_reg   <= pump_locked_next;
            vent_active_reg   <= vent_active_next;
            vent_mark_reg     <= vent_mark_next;
        end
    end

    // Output register
    logic [M_DATA_W-1:0] out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_take)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg <= {3'b000, night, vent_on, pump_running_next, heater_on, lamp_on};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

// ===== sim/greenhouse_climate_controller_unit_tb.sv =====
module greenhouse_climate_controller_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ghcc_pkg::*;

    localparam int IDLE_LIMIT    = 2000;
    localparam int DRAIN_CYCLES  = 4;
    localparam int RANDOM_PHASES = 6;
    localparam int PHASE_TICKS   = 92;

    // One control tick as it travels on the input stream
    typedef struct packed {
        logic [TIME_W-1:0]                now;
        logic [3:0][SAMPLE_W-1:0]         light;
        logic [3:0][SAMPLE_W-1:0]         soil;
        logic signed [TEMP_W-1:0]         temp;
        logic [HUM_W-1:0]                 hum;
        logic                             hum_ok;
    } tick_t;

    // Drive bits of one result word
    typedef struct packed {
        logic lamp;
        logic heater;
        logic pump;
        logic vent;
        logic night;
    } drives_t;

    logic                 clk;
    logic                 rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [S_DATA_W-1:0]  s_axis_tdata;
    logic [0:0]           s_axis_tuser;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [M_DATA_W-1:0]  m_axis_tdata;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DAT_W-1:0] cfg_data;

    // Controller registers as the predictor sees them
    logic [SAMPLE_W-1:0]      light_th      = LIGHT_TH_RST;
    logic [SAMPLE_W-1:0]      soil_th       = SOIL_TH_RST;
    logic signed [TEMP_W-1:0] heat_th       = HEAT_TH_RST;
    logic [HUM_W-1:0]         hum_high      = HUM_HIGH_RST;
    logic [TIME_W-1:0]        pump_max      = PUMP_MAX_RST;
    logic [TIME_W-1:0]        vent_interval = VENT_INTERVAL_RST;
    logic [TIME_W-1:0]        vent_duration = VENT_DURATION_RST;
    logic [HALF_W-1:0]        half_cycle    = HALF_CYCLE_RST;

    // Controller state as the predictor sees it
    logic [TIME_W-1:0] cycle_start   = '0;
    logic [TIME_W-1:0] pump_start    = '0;
    logic [TIME_W-1:0] lockout_start = '0;
    logic [TIME_W-1:0] vent_mark     = '0;
    logic              pump_running  = 1'b0;
    logic              pump_locked   = 1'b0;
    logic              vent_active   = 1'b0;

    drives_t expected_drives[$];
    int      mismatch_count = 0;
    int      results_seen   = 0;
    int      idle_cycles    = 0;

    // Sender burst shaping and receiver stall pattern
    int      burst_left  = 0;
    bit      idle_enable = 1'b1;
    int      rx_mode     = 0;
    int      rx_period   = 7;
    int      rx_stall    = 2;
    int      rx_count    = 0;
    logic [TIME_W-1:0] now_ms = '0;

    greenhouse_climate_controller_unit #(
        .LIGHT_SENSORS (LIGHT_SENSORS_DEF),
        .SOIL_SENSORS  (SOIL_SENSORS_DEF)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Truncating mean over the sensors in use, count held to 1..4
    function automatic logic [31:0] sample_mean(logic [3:0][SAMPLE_W-1:0] s, int count);
        int          n;
        logic [31:0] sum;
        n   = (count < 1) ? 1 : (count > SENSOR_MAX) ? SENSOR_MAX : count;
        sum = '0;
        for (int k = 0; k < n; k++)
        begin
            sum += 32'(s[k]);
        end
        return sum / n;
    endfunction

    // Advance the controller state by one tick and return its drive bits
    function automatic drives_t predict_drives(tick_t t);
        drives_t           d;
        logic [TIME_W-1:0] elapsed;
        logic              needed;
        elapsed = t.now - cycle_start;
        if (elapsed < {1'b0, half_cycle})
        begin
            d.night = 1'b0;
        end
        else if (elapsed < {half_cycle, 1'b0})
        begin
            d.night = 1'b1;
        end
        else
        begin
            cycle_start = t.now;
            d.night     = 1'b0;
        end

        d.lamp   = !d.night && (sample_mean(t.light, LIGHT_SENSORS_DEF) > light_th);
        d.heater = $signed(t.temp) < $signed(heat_th);

        // Vent schedule: open at the interval, close after the duration
        if (!vent_active && ((t.now - vent_mark) >= vent_interval))
        begin
            vent_active = 1'b1;
            vent_mark   = t.now;
        end
        if (vent_active && ((t.now - vent_mark) >= vent_duration))
        begin
            vent_active = 1'b0;
            vent_mark   = t.now;
        end

        // Pump run, timeout and lockout
        needed = sample_mean(t.soil, SOIL_SENSORS_DEF) > soil_th;
        if (pump_running)
        begin
            if (!needed)
            begin
                pump_running = 1'b0;
            end
            else if ((t.now - pump_start) > pump_max)
            begin
                pump_running  = 1'b0;
                lockout_start = t.now;
                pump_locked   = 1'b1;
            end
        end
        else if (needed && !pump_locked)
        begin
            pump_running = 1'b1;
            pump_start   = t.now;
        end
        if ((t.now - lockout_start) > LOCKOUT_MS)
        begin
            pump_locked = 1'b0;
        end

        d.pump = pump_running;
        d.vent = vent_active || (t.hum_ok && (t.hum > hum_high)) || d.heater || pump_running;
        return d;
    endfunction

    // Directed tick with the unused samples left random
    function automatic tick_t mk_tick(logic [TIME_W-1:0] now, logic [SAMPLE_W-1:0] light,
                                      logic [SAMPLE_W-1:0] soil, logic [TEMP_W-1:0] temp,
                                      logic [HUM_W-1:0] hum, logic hum_ok);
        tick_t t;
        for (int k = 0; k < 4; k++)
        begin
            t.light[k] = SAMPLE_W'($urandom_range(0, 1023));
            t.soil[k]  = SAMPLE_W'($urandom_range(0, 1023));
        end
        t.now      = now;
        t.light[0] = light;
        t.soil[0]  = soil;
        t.temp     = temp;
        t.hum      = hum;
        t.hum_ok   = hum_ok;
        return t;
    endfunction

    // Send one tick word, with a random gap at the start of each burst
    task automatic send_tick(tick_t t);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap        = idle_enable ? $urandom_range(0, 6) : 0;
            repeat (gap)
            begin
                @(negedge clk);
                s_axis_tvalid <= 1'b0;
            end
        end
        burst_left--;
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, t.hum, t.temp, t.soil, t.light, t.now};
        s_axis_tuser  <= t.hum_ok;
        @(posedge clk);
        while (!s_axis_tready)
        begin
            @(posedge clk);
        end
        expected_drives.push_back(predict_drives(t));
    endtask

    // Hold off the sender until every expected word has come back
    task automatic wait_results_drained();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (expected_drives.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Write one register; the block must be idle
    task automatic write_reg(cfg_reg_t idx, logic [CFG_DAT_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        case (idx)
            CFG_LIGHT_TH:      light_th      = value[SAMPLE_W-1:0];
            CFG_SOIL_TH:       soil_th       = value[SAMPLE_W-1:0];
            CFG_HEAT_TH:       heat_th       = value[TEMP_W-1:0];
            CFG_HUM_HIGH:      hum_high      = value[HUM_W-1:0];
            CFG_PUMP_MAX:      pump_max      = value;
            CFG_VENT_INTERVAL: vent_interval = value;
            CFG_VENT_DURATION: vent_duration = value;
            CFG_HALF_CYCLE:    half_cycle    = value[HALF_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Field extremes and threshold boundaries under the reset settings
    task automatic test_field_extremes();
        send_tick(mk_tick(32'd0, 10'd0, 10'd0, -8'sd128, 7'd0, 1'b0));
        send_tick(mk_tick(32'd1, 10'd1023, 10'd1023, 8'sd127, 7'd127, 1'b1));
        send_tick(mk_tick(32'd2, 10'd405, 10'd500, 8'sd20, 7'd75, 1'b1));
        send_tick(mk_tick(32'd3, 10'd406, 10'd501, 8'sd19, 7'd76, 1'b0));
        send_tick(mk_tick(32'd10000, 10'd1023, 10'd0, -8'sd40, 7'd100, 1'b1));
        send_tick(mk_tick(32'd20000, 10'd1023, 10'd0, 8'sd80, 7'd76, 1'b1));
    endtask

    // Day, night and restart, zero half cycle, longest half cycle and time wrap
    task automatic test_day_night_timer();
        wait_results_drained();
        write_reg(CFG_HALF_CYCLE, 32'd3);
        send_tick(mk_tick(32'd20100, 10'd900, 10'd0, 8'sd30, 7'd0, 1'b0));
        send_tick(mk_tick(32'd20103, 10'd900, 10'd0, 8'sd30, 7'd0, 1'b0));
        send_tick(mk_tick(32'd20105, 10'd900, 10'd0, 8'sd30, 7'd0, 1'b0));
        send_tick(mk_tick(32'd20106, 10'd900, 10'd0, 8'sd30, 7'd0, 1'b0));
        wait_results_drained();
        write_reg(CFG_HALF_CYCLE, 32'd0);
        send_tick(mk_tick(32'd20107, 10'd900, 10'd0, 8'sd30, 7'd0, 1'b0));
        wait_results_drained();
        write_reg(CFG_HALF_CYCLE, 32'h7FFF_FFFF);
        send_tick(mk_tick(32'hFFFF_FFF0, 10'd900, 10'd0, 8'sd30, 7'd0, 1'b0));
        send_tick(mk_tick(32'h0000_0005, 10'd900, 10'd0, 8'sd30, 7'd0, 1'b0));
    endtask

    // Pump timeout, lockout boundary and restart after the lockout
    task automatic test_pump_timeout_lockout();
        wait_results_drained();
        write_reg(CFG_HALF_CYCLE, 32'd10000);
        write_reg(CFG_PUMP_MAX, 32'd10);
        send_tick(mk_tick(32'd1000, 10'd0, 10'd600, 8'sd30, 7'd0, 1'b0));
        send_tick(mk_tick(32'd1010, 10'd0, 10'd600, 8'sd30, 7'd0, 1'b0));
        send_tick(mk_tick(32'd1011, 10'd0, 10'd600, 8'sd30, 7'd0, 1'b0));
        send_tick(mk_tick(32'd6011, 10'd0, 10'd600, 8'sd30, 7'd0, 1'b0));
        send_tick(mk_tick(32'd6012, 10'd0, 10'd600, 8'sd30, 7'd0, 1'b0));
        send_tick(mk_tick(32'd6013, 10'd0, 10'd600, 8'sd30, 7'd0, 1'b0));
        send_tick(mk_tick(32'd6014, 10'd0, 10'd100, 8'sd30, 7'd0, 1'b0));
    endtask

    // Scheduled ventilation, then a zero duration
    task automatic test_vent_schedule();
        wait_results_drained();
        write_reg(CFG_HEAT_TH, 32'h80);
        write_reg(CFG_VENT_INTERVAL, 32'd20);
        write_reg(CFG_VENT_DURATION, 32'd5);
        send_tick(mk_tick(32'd7000, 10'd0, 10'd0, 8'sd0, 7'd0, 1'b0));
        send_tick(mk_tick(32'd7004, 10'd0, 10'd0, 8'sd0, 7'd0, 1'b0));
        send_tick(mk_tick(32'd7005, 10'd0, 10'd0, 8'sd0, 7'd0, 1'b0));
        send_tick(mk_tick(32'd7025, 10'd0, 10'd0, 8'sd0, 7'd0, 1'b0));
        wait_results_drained();
        write_reg(CFG_VENT_DURATION, 32'd0);
        send_tick(mk_tick(32'd7060, 10'd0, 10'd0, 8'sd0, 7'd0, 1'b0));
        send_tick(mk_tick(32'd7100, 10'd0, 10'd0, 8'sd0, 7'd0, 1'b0));
    endtask

    // Random ticks over several register settings, extremes first
    task automatic test_random_phases();
        tick_t t;
        int    pause_at;
        int    r;
        logic  soil_wet;
        logic  light_high;
        soil_wet   = 1'b0;
        light_high = 1'b0;
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            wait_results_drained();
            if (p == 0)
            begin
                write_reg(CFG_LIGHT_TH, 32'd0);
                write_reg(CFG_SOIL_TH, 32'd0);
                write_reg(CFG_HEAT_TH, 32'h80);
                write_reg(CFG_HUM_HIGH, 32'd0);
                write_reg(CFG_PUMP_MAX, 32'd0);
                write_reg(CFG_VENT_INTERVAL, 32'd0);
                write_reg(CFG_VENT_DURATION, 32'd0);
                write_reg(CFG_HALF_CYCLE, 32'd0);
            end
            else if (p == 1)
            begin
                write_reg(CFG_LIGHT_TH, 32'd1023);
                write_reg(CFG_SOIL_TH, 32'd1023);
                write_reg(CFG_HEAT_TH, 32'h7F);
                write_reg(CFG_HUM_HIGH, 32'd127);
                write_reg(CFG_PUMP_MAX, 32'hFFFF_FFFF);
                write_reg(CFG_VENT_INTERVAL, 32'hFFFF_FFFF);
                write_reg(CFG_VENT_DURATION, 32'hFFFF_FFFF);
                write_reg(CFG_HALF_CYCLE, 32'h7FFF_FFFF);
            end
            else
            begin
                write_reg(CFG_LIGHT_TH, $urandom_range(0, 1023));
                write_reg(CFG_SOIL_TH, $urandom_range(0, 1023));
                write_reg(CFG_HEAT_TH, 32'($urandom_range(0, 120) - 40));
                write_reg(CFG_HUM_HIGH, $urandom_range(0, 100));
                write_reg(CFG_PUMP_MAX, $urandom_range(0, 40));
                write_reg(CFG_VENT_INTERVAL, $urandom_range(0, 80));
                write_reg(CFG_VENT_DURATION, $urandom_range(0, 30));
                write_reg(CFG_HALF_CYCLE, $urandom_range(1, 60));
            end
            idle_enable = (p % 3) != 2;
            rx_mode     = p % 3;
            rx_period   = $urandom_range(4, 12);
            rx_stall    = $urandom_range(1, 3);
            pause_at    = $urandom_range(10, PHASE_TICKS - 10);

            for (int i = 0; i < PHASE_TICKS; i++)
            begin
                if (i == pause_at)
                begin
                    wait_results_drained();
                end
                // Advance time mostly in small steps, with rare jumps anywhere
                r = $urandom_range(0, 19);
                if (r == 0)
                begin
                    now_ms = $urandom;
                end
                else if (r < 3)
                begin
                    now_ms += $urandom_range(0, 6000);
                end
                else
                begin
                    now_ms += $urandom_range(0, 12);
                end
                // Wet and bright spells long enough to reach timeouts
                if ($urandom_range(0, 9) == 0)
                begin
                    soil_wet = ~soil_wet;
                end
                if ($urandom_range(0, 7) == 0)
                begin
                    light_high = ~light_high;
                end
                for (int k = 0; k < 4; k++)
                begin
                    t.light[k] = SAMPLE_W'($urandom_range(0, 1023));
                    t.soil[k]  = SAMPLE_W'($urandom_range(0, 1023));
                end
                t.now      = now_ms;
                t.light[0] = light_high ? SAMPLE_W'($urandom_range(light_th, 1023))
                                        : SAMPLE_W'($urandom_range(0, light_th));
                t.soil[0]  = soil_wet ? SAMPLE_W'($urandom_range(soil_th, 1023))
                                      : SAMPLE_W'($urandom_range(0, soil_th));
                if ($urandom_range(0, 7) == 0)
                begin
                    t.temp = 8'($urandom_range(0, 255));
                    t.hum  = HUM_W'($urandom_range(0, 127));
                end
                else
                begin
                    t.temp = 8'($urandom_range(0, 120) - 40);
                    t.hum  = HUM_W'($urandom_range(0, 100));
                end
                t.hum_ok = 1'($urandom_range(0, 1));
                send_tick(t);
            end
        end
    endtask

    // Receiver stall pattern
    initial
    begin
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            case (rx_mode)
                0: m_axis_tready <= 1'b1;
                1: m_axis_tready <= ($urandom_range(0, 2) != 0);
                default:
                begin
                    rx_count++;
                    m_axis_tready <= (rx_count % rx_period) >= rx_stall;
                end
            endcase
        end
    end

    task automatic note_mismatch(string what, logic want, logic got);
        mismatch_count++;
        if (mismatch_count <= 10)
        begin
            $display("mismatch at result %0d on %s: expected %0b, got %0b",
                     results_seen, what, want, got);
        end
    endtask

    // Compare each result word with the oldest expectation
    always @(posedge clk)
    begin
        drives_t want;
        drives_t got;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.lamp   = m_axis_tdata[0];
            got.heater = m_axis_tdata[1];
            got.pump   = m_axis_tdata[2];
            got.vent   = m_axis_tdata[3];
            got.night  = m_axis_tdata[4];
            if (expected_drives.size() == 0)
            begin
                note_mismatch("word with nothing expected", 1'b0, 1'b1);
            end
            else
            begin
                want = expected_drives.pop_front();
                if (got.lamp !== want.lamp)     note_mismatch("lamp_on", want.lamp, got.lamp);
                if (got.heater !== want.heater) note_mismatch("heater_on", want.heater, got.heater);
                if (got.pump !== want.pump)     note_mismatch("pump_on", want.pump, got.pump);
                if (got.vent !== want.vent)     note_mismatch("vent_on", want.vent, got.vent);
                if (got.night !== want.night)   note_mismatch("night", want.night, got.night);
            end
            results_seen++;
        end
    end

    // Watchdog: end the run after too long without any word moving
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (cfg_valid && cfg_ready))
        begin
            idle_cycles = 0;
        end
        else
        begin
            idle_cycles++;
        end
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("greenhouse_climate_controller_unit verification failed");
            $finish;
        end
    end

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        cfg_valid     = 1'b0;
        cfg_index     = CFG_LIGHT_TH;
        cfg_data      = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_field_extremes();
        test_day_night_timer();
        test_pump_timeout_lockout();
        test_vent_schedule();
        test_random_phases();
        wait_results_drained();

        if (mismatch_count == 0 && expected_drives.size() == 0)
        begin
            $display("greenhouse_climate_controller_unit verification clean");
        end
        else
        begin
            $display("greenhouse_climate_controller_unit verification failed");
        end
        $finish;
    end

endmodule
